>>> sv/aes128_single_round_assert.svh
// Assertion macros for the single-round AES-128 block.
`ifndef AES128_SINGLE_ROUND_ASSERT_SVH
`define AES128_SINGLE_ROUND_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AES_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes128 same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes128 next-cycle check failed");
`else
`define AES_ASSERT_IMPL(lbl, ante, cons)
`define AES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/aes128_pkg.sv
// Types, S-box table and GF(2^8) helpers shared by the AES-128 round block.
package aes128_pkg;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    typedef struct packed {
        logic [63:0] state_hi;
        logic [63:0] state_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } in_payload_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
        logic [63:0] round_key_hi;
        logic [63:0] round_key_lo;
    } out_payload_t;

    localparam byte_t RCON_1    = 8'h01;
    localparam byte_t GF_REDUCE = 8'h1b;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t sub_byte(input byte_t b);
        return SBOX[b];
    endfunction

    // Multiply by x modulo x^8+x^4+x^3+x+1.
    function automatic byte_t xtime(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
    endfunction

    // Byte k of a block, byte 0 in the top bits.
    function automatic byte_t get_byte(input block_t blk, input logic [3:0] k);
        return blk[8'd127 - {k, 3'b000} -: 8];
    endfunction

endpackage

>>> sv/aes128_if.sv
// Valid/ready channel interfaces for the AES-128 round block.
interface aes128_in_if;
    import aes128_pkg::*;

    logic        valid;
    logic        ready;
    in_payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aes128_out_if;
    import aes128_pkg::*;

    logic         valid;
    logic         ready;
    out_payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/aes128_key_exp.sv
// Round key 1 expansion from the cipher key (Rcon 0x01).
module aes128_key_exp (
    input  aes128_pkg::block_t key,
    output aes128_pkg::block_t round_key
);
    import aes128_pkg::*;

    logic [31:0] w0, w1, w2, w3;
    logic [31:0] w4, w5, w6, w7;
    logic [31:0] temp;

    assign w0 = key[127:96];
    assign w1 = key[95:64];
    assign w2 = key[63:32];
    assign w3 = key[31:0];

    // SubWord(RotWord(w3)) ^ Rcon
    assign temp = {sub_byte(w3[23:16]) ^ RCON_1, sub_byte(w3[15:8]),
                   sub_byte(w3[7:0]), sub_byte(w3[31:24])};

    assign w4 = w0 ^ temp;
    assign w5 = w1 ^ w4;
    assign w6 = w2 ^ w5;
    assign w7 = w3 ^ w6;

    assign round_key = {w4, w5, w6, w7};
endmodule

>>> sv/aes128_round.sv
// Initial AddRoundKey plus one full AES round on a 128-bit state.
module aes128_round (
    input  aes128_pkg::block_t state,
    input  aes128_pkg::block_t key,
    input  aes128_pkg::block_t round_key,
    output aes128_pkg::block_t result
);
    import aes128_pkg::*;

    byte_t sb [16];
    byte_t sh [16];
    byte_t mx [16];

    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            sb[k] = sub_byte(get_byte(state, 4'(k)) ^ get_byte(key, 4'(k)));
        end
        // row r rotates left by r columns
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[r + 4 * c] = sb[r + 4 * ((c + r) % 4)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            mx[4 * c]     = xtime(sh[4 * c]) ^ xtime(sh[4 * c + 1]) ^ sh[4 * c + 1]
                            ^ sh[4 * c + 2] ^ sh[4 * c + 3];
            mx[4 * c + 1] = sh[4 * c] ^ xtime(sh[4 * c + 1]) ^ xtime(sh[4 * c + 2])
                            ^ sh[4 * c + 2] ^ sh[4 * c + 3];
            mx[4 * c + 2] = sh[4 * c] ^ sh[4 * c + 1] ^ xtime(sh[4 * c + 2])
                            ^ xtime(sh[4 * c + 3]) ^ sh[4 * c + 3];
            mx[4 * c + 3] = xtime(sh[4 * c]) ^ sh[4 * c] ^ sh[4 * c + 1]
                            ^ sh[4 * c + 2] ^ xtime(sh[4 * c + 3]);
        end
        for (int k = 0; k < 16; k++)
        begin
            result[127 - 8 * k -: 8] = mx[k] ^ get_byte(round_key, 4'(k));
        end
    end
endmodule

>>> sv/aes128_single_round.sv
// Top level: registered AES-128 initial AddRoundKey plus one round, with round key 1.
//
// aes128_single_round takes a 128-bit state and a 128-bit cipher key per input
// transaction (FIPS-197 byte order, byte 0 in the top bits of the _hi halves) and
// returns, in one output transaction, the state after the initial AddRoundKey and
// one full round (SubBytes, ShiftRows, MixColumns, AddRoundKey) together with
// round key 1 (w4..w7). Throughput is one transaction per cycle while the output
// channel is not stalled. A transaction accepted on the input channel sits in the
// input register, and its result is loaded into the result register, which drives
// the output channel. The logic between them is the initial AddRoundKey XOR, one
// S-box lookup per byte, the MixColumns XOR tree and the final AddRoundKey XOR;
// the round key path (four S-box lookups and a chain of four word XORs) feeds it.
// in_ch.ready depends combinationally on out_ch.ready only when both registers
// are full; otherwise the block keeps taking input while a result waits.
`include "aes128_single_round_assert.svh"

module aes128_single_round (
    input  logic         clk,
    input  logic         rst_n,
    aes128_in_if.sink    in_ch,
    aes128_out_if.source out_ch
);
    import aes128_pkg::*;

    // stage 1: captured input transaction
    logic        s1_valid_reg;
    in_payload_t s1_data_reg;

    // stage 2: result register feeding the output channel
    logic         out_valid_reg;
    out_payload_t out_data_reg;

    logic         out_adv;     // result register can load this cycle
    logic         in_take;     // input transaction accepted
    block_t       s1_state;
    block_t       s1_key;
    block_t       rk;
    block_t       res;
    out_payload_t out_data_next;

    assign out_adv = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || out_adv;
    assign in_take = in_ch.valid && in_ch.ready;

    assign s1_state = {s1_data_reg.state_hi, s1_data_reg.state_lo};
    assign s1_key   = {s1_data_reg.key_hi, s1_data_reg.key_lo};

    aes128_key_exp u_key_exp (
        .key       (s1_key),
        .round_key (rk)
    );

    aes128_round u_round (
        .state     (s1_state),
        .key       (s1_key),
        .round_key (rk),
        .result    (res)
    );

    assign out_data_next = '{result_hi:    res[127:64],
                             result_lo:    res[63:0],
                             round_key_hi: rk[127:64],
                             round_key_lo: rk[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_ch.data;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // an accepted transaction always lands in stage 1
    `AES_ASSERT_NEXT(a_take_fills_s1, in_take, s1_valid_reg)
    // stage 1 moving forward always produces a result
    `AES_ASSERT_NEXT(a_s1_moves_out, s1_valid_reg && out_adv, out_ch.valid)
    // input stalls only when both registers hold data and the output is blocked
    `AES_ASSERT_IMPL(a_stall_only_full, !in_ch.ready,
                     s1_valid_reg && out_valid_reg && !out_ch.ready)
endmodule
